// ===== sv/lavm_pkg.sv =====
// Shared constants and types for the look-at view matrix unit.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package lavm_pkg;

    localparam int COORD_W   = 32;              // input coordinate width
    localparam int FRAC_BITS = 16;              // fraction bits of all fixed-point values
    localparam int ENTRY_W   = 18;              // rotation entry port width
    localparam int TRANS_W   = 32;              // translation port width
    localparam int NORM_BITS = 30;              // prescaled magnitudes sit in [2^29, 2^30)
    localparam int DIFF_W    = COORD_W + 1;     // eye - target
    localparam int FQ_W      = FRAC_BITS + 2;   // signed unit-vector component
    localparam int CROSS_W   = NORM_BITS + FQ_W + 2; // up x forward component
    localparam int ROWS_PER_ITEM = 3;

    typedef enum logic [1:0] {
        ROW_RIGHT = 2'd0,
        ROW_CAMUP = 2'd1,
        ROW_FWD   = 2'd2
    } row_t;

    // status of a normalized vector leaving a normalizer
    typedef struct packed {
        logic valid;
        logic ok;
    } norm_ctl_t;

endpackage

// ===== sv/look_at_view_matrix_unit.sv =====
// Look-at view matrix unit. Each accepted request yields three rows, which are
// taken in order, right row first, from the single row output port.
// New requests are accepted while earlier ones are still in flight; busy is high
// after each accepted request so that rows of successive requests never overlap.
// Reset clears all valid bits and the row sequencer; requests in flight drop.
// Results cannot be stalled: each row is on the ports for one cycle with done.
`timescale 1ns / 1ps

module look_at_view_matrix_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [lavm_pkg::COORD_W-1:0]    eye_x,
    input  logic signed [lavm_pkg::COORD_W-1:0]    eye_y,
    input  logic signed [lavm_pkg::COORD_W-1:0]    eye_z,
    input  logic signed [lavm_pkg::COORD_W-1:0]    target_x,
    input  logic signed [lavm_pkg::COORD_W-1:0]    target_y,
    input  logic signed [lavm_pkg::COORD_W-1:0]    target_z,
    input  logic signed [lavm_pkg::COORD_W-1:0]    up_x,
    input  logic signed [lavm_pkg::COORD_W-1:0]    up_y,
    input  logic signed [lavm_pkg::COORD_W-1:0]    up_z,
    output logic                                   done,
    output logic [1:0]                             row_index,
    output logic signed [lavm_pkg::ENTRY_W-1:0]    entry_x,
    output logic signed [lavm_pkg::ENTRY_W-1:0]    entry_y,
    output logic signed [lavm_pkg::ENTRY_W-1:0]    entry_z,
    output logic signed [lavm_pkg::TRANS_W-1:0]    translation,
    output logic                                   degenerate,
    output logic                                   last_row
);

    localparam int CW     = lavm_pkg::COORD_W;
    localparam int DW     = lavm_pkg::DIFF_W;
    localparam int FQ_W   = lavm_pkg::FQ_W;
    localparam int EW     = lavm_pkg::ENTRY_W;
    localparam int TW     = lavm_pkg::TRANS_W;
    localparam int SIDE1  = 6 * CW;
    localparam int SIDE2  = 3 * CW + 3 * FQ_W;
    localparam int GAP    = lavm_pkg::ROWS_PER_ITEM - 1;
    localparam int GAP_W  = $clog2(GAP + 1);

    logic accept;

    logic [GAP_W-1:0] busy_cnt_reg;
    logic [GAP_W-1:0] busy_cnt_next;

    // input register
    logic                 in_valid_reg;
    logic signed [DW-1:0] d_reg   [3];
    logic signed [CW-1:0] eye_reg [3];
    logic signed [CW-1:0] up_reg  [3];

    lavm_pkg::norm_ctl_t    n1_ctl;
    logic signed [FQ_W-1:0] n1_fwd [3];
    logic [SIDE1-1:0]       n1_side;
    logic signed [CW-1:0]   n1_eye [3];
    logic signed [CW-1:0]   n1_up  [3];

    logic                   x_valid;
    logic signed [lavm_pkg::CROSS_W-1:0] x_rc [3];
    logic signed [FQ_W-1:0] x_fwd [3];
    logic signed [CW-1:0]   x_eye [3];

    lavm_pkg::norm_ctl_t    n2_ctl;
    logic signed [FQ_W-1:0] n2_right [3];
    logic [SIDE2-1:0]       n2_side;
    logic signed [FQ_W-1:0] n2_fwd [3];
    logic signed [CW-1:0]   n2_eye [3];

    logic                 r_valid;
    logic                 r_degen;
    logic signed [EW-1:0] r_ent [3][3];
    logic signed [TW-1:0] r_trans [3];

    // row sequencer and result bank
    logic                 emit_valid_reg;
    logic                 emit_valid_next;
    lavm_pkg::row_t       emit_row_reg;
    lavm_pkg::row_t       emit_row_next;
    logic signed [EW-1:0] bank_ent_reg [3][3];
    logic signed [TW-1:0] bank_tr_reg [3];
    logic                 bank_degen_reg;

    assign accept = start && !busy;
    assign busy   = busy_cnt_reg != '0;

    always_comb
    begin
        if (accept)
        begin
            busy_cnt_next = GAP_W'(GAP);
        end
        else if (busy_cnt_reg != '0)
        begin
            busy_cnt_next = busy_cnt_reg - GAP_W'(1);
        end
        else
        begin
            busy_cnt_next = busy_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_cnt_reg   <= '0;
            in_valid_reg   <= 1'b0;
            emit_valid_reg <= 1'b0;
            emit_row_reg   <= lavm_pkg::ROW_RIGHT;
        end
        else
        begin
            busy_cnt_reg   <= busy_cnt_next;
            in_valid_reg   <= accept;
            emit_valid_reg <= emit_valid_next;
            emit_row_reg   <= emit_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0]   <= DW'(eye_x) - DW'(target_x);
        d_reg[1]   <= DW'(eye_y) - DW'(target_y);
        d_reg[2]   <= DW'(eye_z) - DW'(target_z);
        eye_reg[0] <= eye_x;
        eye_reg[1] <= eye_y;
        eye_reg[2] <= eye_z;
        up_reg[0]  <= up_x;
        up_reg[1]  <= up_y;
        up_reg[2]  <= up_z;
        if (r_valid)
        begin
            bank_ent_reg   <= r_ent;
            bank_tr_reg    <= r_trans;
            bank_degen_reg <= r_degen;
        end
    end

    // forward = normalize(eye - target)
    lavm_norm #(
        .IN_W   (DW),
        .SIDE_W (SIDE1)
    ) u_norm_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .vec      (d_reg),
        .side_in  ({eye_reg[0], eye_reg[1], eye_reg[2], up_reg[0], up_reg[1], up_reg[2]}),
        .out_ctl  (n1_ctl),
        .out_vec  (n1_fwd),
        .side_out (n1_side)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_up[i]  = $signed(n1_side[(2-i)*CW +: CW]);
            n1_eye[i] = $signed(n1_side[3*CW + (2-i)*CW +: CW]);
            n2_fwd[i] = $signed(n2_side[(2-i)*FQ_W +: FQ_W]);
            n2_eye[i] = $signed(n2_side[3*FQ_W + (2-i)*CW +: CW]);
        end
    end

    // a zero forward gives a zero cross product, so the second normalizer
    // flags the degenerate case for both
    lavm_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n1_ctl.valid),
        .fwd       (n1_fwd),
        .up        (n1_up),
        .eye       (n1_eye),
        .out_valid (x_valid),
        .rc        (x_rc),
        .fwd_out   (x_fwd),
        .eye_out   (x_eye)
    );

    lavm_norm #(
        .IN_W   (lavm_pkg::CROSS_W),
        .SIDE_W (SIDE2)
    ) u_norm_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (x_valid),
        .vec      (x_rc),
        .side_in  ({x_eye[0], x_eye[1], x_eye[2], x_fwd[0], x_fwd[1], x_fwd[2]}),
        .out_ctl  (n2_ctl),
        .out_vec  (n2_right),
        .side_out (n2_side)
    );

    lavm_rows u_rows (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (n2_ctl),
        .right     (n2_right),
        .fwd       (n2_fwd),
        .eye       (n2_eye),
        .out_valid (r_valid),
        .out_degen (r_degen),
        .out_ent   (r_ent),
        .out_trans (r_trans)
    );

    // next state of the row sequencer
    always_comb
    begin
        emit_valid_next = emit_valid_reg;
        emit_row_next   = emit_row_reg;
        if (r_valid)
        begin
            emit_valid_next = 1'b1;
            emit_row_next   = lavm_pkg::ROW_RIGHT;
        end
        else if (emit_valid_reg)
        begin
            unique case (emit_row_reg)
                lavm_pkg::ROW_RIGHT: emit_row_next = lavm_pkg::ROW_CAMUP;
                lavm_pkg::ROW_CAMUP: emit_row_next = lavm_pkg::ROW_FWD;
                default:
                begin
                    emit_valid_next = 1'b0;
                    emit_row_next   = lavm_pkg::ROW_RIGHT;
                end
            endcase
        end
    end

    // outputs of the row sequencer
    always_comb
    begin
        done       = emit_valid_reg;
        row_index  = emit_row_reg;
        degenerate = bank_degen_reg;
        last_row   = emit_valid_reg && (emit_row_reg == lavm_pkg::ROW_FWD);
        unique case (emit_row_reg)
            lavm_pkg::ROW_RIGHT:
            begin
                entry_x     = bank_ent_reg[0][0];
                entry_y     = bank_ent_reg[0][1];
                entry_z     = bank_ent_reg[0][2];
                translation = bank_tr_reg[0];
            end
            lavm_pkg::ROW_CAMUP:
            begin
                entry_x     = bank_ent_reg[1][0];
                entry_y     = bank_ent_reg[1][1];
                entry_z     = bank_ent_reg[1][2];
                translation = bank_tr_reg[1];
            end
            lavm_pkg::ROW_FWD:
            begin
                entry_x     = bank_ent_reg[2][0];
                entry_y     = bank_ent_reg[2][1];
                entry_z     = bank_ent_reg[2][2];
                translation = bank_tr_reg[2];
            end
            default:
            begin
                entry_x     = '0;
                entry_y     = '0;
                entry_z     = '0;
                translation = '0;
            end
        endcase
    end

endmodule

// ===== sv/lavm_prescale.sv =====
// Vector prescaler: sign/magnitude split, bit-length search, shift of all
// three magnitudes so the largest lands in [2^29, 2^30). Uses lavm_pkg.
`timescale 1ns / 1ps

module lavm_prescale #(
    parameter int IN_W   = lavm_pkg::DIFF_W,
    parameter int SIDE_W = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [IN_W-1:0]               vec [3],
    input  logic [SIDE_W-1:0]                    side_in,
    output logic                                 out_valid,
    output logic                                 out_nz,
    output logic [lavm_pkg::NORM_BITS-1:0]       out_mag [3],
    output logic [2:0]                           out_neg,
    output logic [SIDE_W-1:0]                    side_out
);

    localparam int NB    = lavm_pkg::NORM_BITS;
    localparam int CHUNK = 8;
    localparam int NCH   = (IN_W + CHUNK - 1) / CHUNK;
    localparam int PAD_W = NCH * CHUNK;
    localparam int CL_W  = $clog2(CHUNK + 1);
    localparam int LEN_W = $clog2(PAD_W + 1);
    localparam int SH_W  = IN_W + NB;

    // stage 1: magnitudes
    logic              v1_reg;
    logic [IN_W-1:0]   mag1_reg [3];
    logic [IN_W-1:0]   mag1_next [3];
    logic [2:0]        neg1_reg;
    logic [IN_W-1:0]   or1_reg;
    logic [SIDE_W-1:0] side1_reg;

    // stage 2: per-chunk bit length
    logic              v2_reg;
    logic [IN_W-1:0]   mag2_reg [3];
    logic [2:0]        neg2_reg;
    logic [CL_W-1:0]   clen2_reg [NCH];
    logic [CL_W-1:0]   clen2_next [NCH];
    logic [NCH-1:0]    cnz2_reg;
    logic [NCH-1:0]    cnz2_next;
    logic [SIDE_W-1:0] side2_reg;

    // stage 3: bit length of the largest magnitude
    logic              v3_reg;
    logic [IN_W-1:0]   mag3_reg [3];
    logic [2:0]        neg3_reg;
    logic [LEN_W-1:0]  len3_reg;
    logic [LEN_W-1:0]  len3_next;
    logic              nz3_reg;
    logic [SIDE_W-1:0] side3_reg;

    // stage 4: shifted magnitudes
    logic              v4_reg;
    logic [NB-1:0]     mag4_reg [3];
    logic [NB-1:0]     mag4_next [3];
    logic [2:0]        neg4_reg;
    logic              nz4_reg;
    logic [SIDE_W-1:0] side4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag1_next[i] = vec[i][IN_W-1] ? $unsigned(-vec[i]) : $unsigned(vec[i]);
        end
    end

    always_comb
    begin
        logic [PAD_W-1:0] padded;
        logic [CHUNK-1:0] chunk;
        padded = PAD_W'(or1_reg);
        for (int c = 0; c < NCH; c++)
        begin
            chunk = padded[c*CHUNK +: CHUNK];
            clen2_next[c] = '0;
            for (int b = 0; b < CHUNK; b++)
            begin
                if (chunk[b])
                begin
                    clen2_next[c] = CL_W'(b + 1);
                end
            end
            cnz2_next[c] = |chunk;
        end
    end

    always_comb
    begin
        len3_next = '0;
        for (int c = 0; c < NCH; c++)
        begin
            if (cnz2_reg[c])
            begin
                len3_next = LEN_W'(c * CHUNK) + LEN_W'(clen2_reg[c]);
            end
        end
    end

    always_comb
    begin
        logic [SH_W-1:0] wide;
        logic [SH_W-1:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            wide = SH_W'(mag3_reg[i]);
            if (len3_reg > LEN_W'(NB))
            begin
                sh = wide >> (len3_reg - LEN_W'(NB));
            end
            else
            begin
                sh = wide << (LEN_W'(NB) - len3_reg);
            end
            mag4_next[i] = sh[NB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag1_reg  <= mag1_next;
        neg1_reg  <= {vec[2][IN_W-1], vec[1][IN_W-1], vec[0][IN_W-1]};
        or1_reg   <= mag1_next[0] | mag1_next[1] | mag1_next[2];
        side1_reg <= side_in;

        mag2_reg  <= mag1_reg;
        neg2_reg  <= neg1_reg;
        clen2_reg <= clen2_next;
        cnz2_reg  <= cnz2_next;
        side2_reg <= side1_reg;

        mag3_reg  <= mag2_reg;
        neg3_reg  <= neg2_reg;
        len3_reg  <= len3_next;
        nz3_reg   <= |cnz2_reg;
        side3_reg <= side2_reg;

        mag4_reg  <= mag4_next;
        neg4_reg  <= neg3_reg;
        nz4_reg   <= nz3_reg;
        side4_reg <= side3_reg;
    end

    assign out_valid = v4_reg;
    assign out_nz    = nz4_reg;
    assign out_mag   = mag4_reg;
    assign out_neg   = neg4_reg;
    assign side_out  = side4_reg;

endmodule

// ===== sv/lavm_norm.sv =====
// Vector normalizer: prescale, sum of squares, one-bit-per-stage square
// root, one-bit-per-stage rounded divide. Uses lavm_pkg and lavm_prescale.
`timescale 1ns / 1ps

module lavm_norm #(
    parameter int IN_W   = lavm_pkg::DIFF_W,
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [IN_W-1:0]           vec [3],
    input  logic [SIDE_W-1:0]                side_in,
    output lavm_pkg::norm_ctl_t              out_ctl,
    output logic signed [lavm_pkg::FQ_W-1:0] out_vec [3],
    output logic [SIDE_W-1:0]                side_out
);

    localparam int NB     = lavm_pkg::NORM_BITS;
    localparam int F      = lavm_pkg::FRAC_BITS;
    localparam int FQ_W   = lavm_pkg::FQ_W;
    localparam int ROOT_W = NB + 1;
    localparam int SQ_W   = 2 * NB + 2;
    localparam int SUB_W  = SQ_W + 2;
    localparam int Q_W    = F + 1;
    localparam int NUM_W  = NB + F + 1;
    localparam int DS_W   = ROOT_W + Q_W;
    localparam int CMP_W  = (NUM_W > DS_W) ? NUM_W : DS_W;

    logic              p_valid;
    logic              p_nz;
    logic [NB-1:0]     p_mag [3];
    logic [2:0]        p_neg;
    logic [SIDE_W-1:0] p_side;

    lavm_prescale #(
        .IN_W   (IN_W),
        .SIDE_W (SIDE_W)
    ) u_prescale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .vec       (vec),
        .side_in   (side_in),
        .out_valid (p_valid),
        .out_nz    (p_nz),
        .out_mag   (p_mag),
        .out_neg   (p_neg),
        .side_out  (p_side)
    );

    // squares
    logic              q1_valid_reg;
    logic [2*NB-1:0]   q1_sq_reg [3];
    logic [NB-1:0]     q1_mag_reg [3];
    logic [2:0]        q1_neg_reg;
    logic              q1_nz_reg;
    logic [SIDE_W-1:0] q1_side_reg;

    // square root pipeline, index 0 holds the sum
    logic              s_valid_reg [ROOT_W+1];
    logic [SQ_W-1:0]   s_rem_reg   [ROOT_W+1];
    logic [ROOT_W-1:0] s_root_reg  [ROOT_W+1];
    logic [NB-1:0]     s_mag_reg   [ROOT_W+1][3];
    logic [2:0]        s_neg_reg   [ROOT_W+1];
    logic              s_nz_reg    [ROOT_W+1];
    logic [SIDE_W-1:0] s_side_reg  [ROOT_W+1];

    // divide pipeline, index 0 holds the rounded numerators
    logic              d_valid_reg [Q_W+1];
    logic [NUM_W-1:0]  d_rem_reg   [Q_W+1][3];
    logic [Q_W-1:0]    d_q_reg     [Q_W+1][3];
    logic [ROOT_W-1:0] d_len_reg   [Q_W+1];
    logic [2:0]        d_neg_reg   [Q_W+1];
    logic              d_nz_reg    [Q_W+1];
    logic [SIDE_W-1:0] d_side_reg  [Q_W+1];

    logic                   o_valid_reg;
    logic                   o_nz_reg;
    logic signed [FQ_W-1:0] o_vec_reg  [3];
    logic signed [FQ_W-1:0] o_vec_next [3];
    logic [SIDE_W-1:0]      o_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_valid_reg   <= 1'b0;
            s_valid_reg[0] <= 1'b0;
            d_valid_reg[0] <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            q1_valid_reg   <= p_valid;
            s_valid_reg[0] <= q1_valid_reg;
            d_valid_reg[0] <= s_valid_reg[ROOT_W];
            o_valid_reg    <= d_valid_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            q1_sq_reg[i] <= p_mag[i] * p_mag[i];
        end
        q1_mag_reg  <= p_mag;
        q1_neg_reg  <= p_neg;
        q1_nz_reg   <= p_nz;
        q1_side_reg <= p_side;

        s_rem_reg[0]  <= SQ_W'(q1_sq_reg[0]) + SQ_W'(q1_sq_reg[1]) + SQ_W'(q1_sq_reg[2]);
        s_root_reg[0] <= '0;
        s_mag_reg[0]  <= q1_mag_reg;
        s_neg_reg[0]  <= q1_neg_reg;
        s_nz_reg[0]   <= q1_nz_reg;
        s_side_reg[0] <= q1_side_reg;

        // numerator = mag * 2^F + floor(len / 2)
        for (int i = 0; i < 3; i++)
        begin
            d_rem_reg[0][i] <= (NUM_W'(s_mag_reg[ROOT_W][i]) << F)
                               + NUM_W'(s_root_reg[ROOT_W] >> 1);
            d_q_reg[0][i]   <= '0;
        end
        d_len_reg[0]  <= s_root_reg[ROOT_W];
        d_neg_reg[0]  <= s_neg_reg[ROOT_W];
        d_nz_reg[0]   <= s_nz_reg[ROOT_W];
        d_side_reg[0] <= s_side_reg[ROOT_W];

        o_nz_reg   <= d_nz_reg[Q_W];
        o_vec_reg  <= o_vec_next;
        o_side_reg <= d_side_reg[Q_W];
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam int J = ROOT_W - 1 - k;
        logic [SUB_W-1:0] sub_sq;
        logic             take;

        // (r + 2^J)^2 - r^2
        assign sub_sq = (SUB_W'(s_root_reg[k]) << (J + 1)) + (SUB_W'(1) << (2 * J));
        assign take   = SUB_W'(s_rem_reg[k]) >= sub_sq;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                s_valid_reg[k+1] <= s_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (take)
            begin
                s_rem_reg[k+1]  <= SQ_W'(SUB_W'(s_rem_reg[k]) - sub_sq);
                s_root_reg[k+1] <= s_root_reg[k] | (ROOT_W'(1) << J);
            end
            else
            begin
                s_rem_reg[k+1]  <= s_rem_reg[k];
                s_root_reg[k+1] <= s_root_reg[k];
            end
            s_mag_reg[k+1]  <= s_mag_reg[k];
            s_neg_reg[k+1]  <= s_neg_reg[k];
            s_nz_reg[k+1]   <= s_nz_reg[k];
            s_side_reg[k+1] <= s_side_reg[k];
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        localparam int J = Q_W - 1 - k;
        logic [CMP_W-1:0] dsh;
        logic [2:0]       take;

        assign dsh = CMP_W'(d_len_reg[k]) << J;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                take[i] = CMP_W'(d_rem_reg[k][i]) >= dsh;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                d_valid_reg[k+1] <= d_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (take[i])
                begin
                    d_rem_reg[k+1][i] <= NUM_W'(CMP_W'(d_rem_reg[k][i]) - dsh);
                    d_q_reg[k+1][i]   <= d_q_reg[k][i] | (Q_W'(1) << J);
                end
                else
                begin
                    d_rem_reg[k+1][i] <= d_rem_reg[k][i];
                    d_q_reg[k+1][i]   <= d_q_reg[k][i];
                end
            end
            d_len_reg[k+1]  <= d_len_reg[k];
            d_neg_reg[k+1]  <= d_neg_reg[k];
            d_nz_reg[k+1]   <= d_nz_reg[k];
            d_side_reg[k+1] <= d_side_reg[k];
        end
    end

    always_comb
    begin
        logic signed [FQ_W-1:0] qs;
        for (int i = 0; i < 3; i++)
        begin
            qs = $signed(FQ_W'(d_q_reg[Q_W][i]));
            if (!d_nz_reg[Q_W])
            begin
                o_vec_next[i] = '0;
            end
            else if (d_neg_reg[Q_W][i])
            begin
                o_vec_next[i] = -qs;
            end
            else
            begin
                o_vec_next[i] = qs;
            end
        end
    end

    assign out_ctl.valid = o_valid_reg;
    assign out_ctl.ok    = o_nz_reg;
    assign out_vec       = o_vec_reg;
    assign side_out      = o_side_reg;

endmodule

// ===== sv/lavm_cross.sv =====
// Cross product of the prescaled up hint with forward (up x forward).
// Uses lavm_pkg and lavm_prescale.
`timescale 1ns / 1ps

module lavm_cross (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [lavm_pkg::FQ_W-1:0]    fwd [3],
    input  logic signed [lavm_pkg::COORD_W-1:0] up [3],
    input  logic signed [lavm_pkg::COORD_W-1:0] eye [3],
    output logic                                out_valid,
    output logic signed [lavm_pkg::CROSS_W-1:0] rc [3],
    output logic signed [lavm_pkg::FQ_W-1:0]    fwd_out [3],
    output logic signed [lavm_pkg::COORD_W-1:0] eye_out [3]
);

    localparam int NB     = lavm_pkg::NORM_BITS;
    localparam int FQ_W   = lavm_pkg::FQ_W;
    localparam int CW     = lavm_pkg::COORD_W;
    localparam int XW     = lavm_pkg::CROSS_W;
    localparam int PR_W   = NB + 1 + FQ_W;
    localparam int SIDE_W = 3 * CW + 3 * FQ_W;

    logic              p_valid;
    logic              p_nz;
    logic [NB-1:0]     p_mag [3];
    logic [2:0]        p_neg;
    logic [SIDE_W-1:0] p_side;

    lavm_prescale #(
        .IN_W   (CW),
        .SIDE_W (SIDE_W)
    ) u_up_prescale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .vec       (up),
        .side_in   ({eye[0], eye[1], eye[2], fwd[0], fwd[1], fwd[2]}),
        .out_valid (p_valid),
        .out_nz    (p_nz),
        .out_mag   (p_mag),
        .out_neg   (p_neg),
        .side_out  (p_side)
    );

    logic signed [NB:0]     ups [3];
    logic signed [FQ_W-1:0] pf  [3];
    logic signed [CW-1:0]   pe  [3];

    logic                   m_valid_reg;
    logic signed [PR_W-1:0] m_prod_reg  [6];
    logic signed [PR_W-1:0] m_prod_next [6];
    logic signed [FQ_W-1:0] m_fwd_reg   [3];
    logic signed [CW-1:0]   m_eye_reg   [3];

    logic                   x_valid_reg;
    logic signed [XW-1:0]   x_rc_reg  [3];
    logic signed [FQ_W-1:0] x_fwd_reg [3];
    logic signed [CW-1:0]   x_eye_reg [3];

    always_comb
    begin
        logic signed [NB:0] m;
        for (int i = 0; i < 3; i++)
        begin
            // a zero up hint comes out as zero magnitudes regardless of p_nz
            m = $signed({1'b0, p_mag[i]});
            ups[i] = p_neg[i] ? -m : m;
            pf[i]  = $signed(p_side[(2-i)*FQ_W +: FQ_W]);
            pe[i]  = $signed(p_side[3*FQ_W + (2-i)*CW +: CW]);
        end
        m_prod_next[0] = ups[1] * pf[2];
        m_prod_next[1] = ups[2] * pf[1];
        m_prod_next[2] = ups[2] * pf[0];
        m_prod_next[3] = ups[0] * pf[2];
        m_prod_next[4] = ups[0] * pf[1];
        m_prod_next[5] = ups[1] * pf[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            x_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= p_valid;
            x_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_prod_reg <= m_prod_next;
        m_fwd_reg  <= pf;
        m_eye_reg  <= pe;

        x_rc_reg[0] <= XW'(m_prod_reg[0]) - XW'(m_prod_reg[1]);
        x_rc_reg[1] <= XW'(m_prod_reg[2]) - XW'(m_prod_reg[3]);
        x_rc_reg[2] <= XW'(m_prod_reg[4]) - XW'(m_prod_reg[5]);
        x_fwd_reg   <= m_fwd_reg;
        x_eye_reg   <= m_eye_reg;
    end

    assign out_valid = x_valid_reg;
    assign rc        = x_rc_reg;
    assign fwd_out   = x_fwd_reg;
    assign eye_out   = x_eye_reg;

endmodule

// ===== sv/lavm_rows.sv =====
// Row builder: camera up = forward x right with rounding and clamp, then
// translation -(row . eye) for all three rows, saturated. Uses lavm_pkg.
`timescale 1ns / 1ps

module lavm_rows (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lavm_pkg::norm_ctl_t                    in_ctl,
    input  logic signed [lavm_pkg::FQ_W-1:0]       right [3],
    input  logic signed [lavm_pkg::FQ_W-1:0]       fwd [3],
    input  logic signed [lavm_pkg::COORD_W-1:0]    eye [3],
    output logic                                   out_valid,
    output logic                                   out_degen,
    output logic signed [lavm_pkg::ENTRY_W-1:0]    out_ent [3][3],
    output logic signed [lavm_pkg::TRANS_W-1:0]    out_trans [3]
);

    localparam int F      = lavm_pkg::FRAC_BITS;
    localparam int FQ_W   = lavm_pkg::FQ_W;
    localparam int CW     = lavm_pkg::COORD_W;
    localparam int EW     = lavm_pkg::ENTRY_W;
    localparam int TW     = lavm_pkg::TRANS_W;
    localparam int CP_W   = 2 * FQ_W;
    localparam int CU_W   = CP_W + 1;
    localparam int PROD_W = FQ_W + CW;
    localparam int SUM_W  = PROD_W + 2;
    localparam int T_W    = SUM_W + 1;
    localparam logic [CU_W-1:0]       ONE_U = CU_W'(2**F);
    localparam logic [CU_W-1:0]       HALF_U = CU_W'(2**(F-1));
    localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(2**(F-1));
    localparam logic signed [T_W-1:0] T_MAX = T_W'(2**(TW-1) - 1);
    localparam logic signed [T_W-1:0] T_MIN = -T_MAX - T_W'(1);

    // C1: products for camera up
    logic                   c1_valid_reg;
    logic                   c1_ok_reg;
    logic signed [CP_W-1:0] c1_p_reg [6];
    logic signed [FQ_W-1:0] c1_r_reg [3];
    logic signed [FQ_W-1:0] c1_f_reg [3];
    logic signed [CW-1:0]   c1_e_reg [3];

    // C2: differences
    logic                   c2_valid_reg;
    logic                   c2_ok_reg;
    logic signed [CU_W-1:0] c2_d_reg [3];
    logic signed [FQ_W-1:0] c2_r_reg [3];
    logic signed [FQ_W-1:0] c2_f_reg [3];
    logic signed [CW-1:0]   c2_e_reg [3];

    // C3: rows assembled
    logic                   c3_valid_reg;
    logic                   c3_ok_reg;
    logic signed [FQ_W-1:0] c3_cu_next [3];
    logic signed [FQ_W-1:0] c3_ent_reg [3][3];
    logic signed [CW-1:0]   c3_e_reg [3];

    // T1: row * eye products
    logic                     t1_valid_reg;
    logic                     t1_ok_reg;
    logic signed [PROD_W-1:0] t1_p_reg [3][3];
    logic signed [FQ_W-1:0]   t1_ent_reg [3][3];

    // T2: rounded dot products
    logic                    t2_valid_reg;
    logic                    t2_ok_reg;
    logic signed [SUM_W-1:0] t2_rnd_reg  [3];
    logic signed [SUM_W-1:0] t2_rnd_next [3];
    logic signed [FQ_W-1:0]  t2_ent_reg [3][3];

    // T3: output
    logic                  t3_valid_reg;
    logic                  t3_degen_reg;
    logic signed [EW-1:0]  t3_ent_reg [3][3];
    logic signed [EW-1:0]  t3_ent_next [3][3];
    logic signed [TW-1:0]  t3_tr_reg  [3];
    logic signed [TW-1:0]  t3_tr_next [3];

    always_comb
    begin
        logic [CU_W-1:0] m;
        logic [CU_W-1:0] rm;
        logic signed [FQ_W-1:0] rs;
        for (int i = 0; i < 3; i++)
        begin
            // round half away from zero, then clamp to [-1, 1]
            m  = c2_d_reg[i][CU_W-1] ? $unsigned(-c2_d_reg[i]) : $unsigned(c2_d_reg[i]);
            rm = (m + HALF_U) >> F;
            if (rm > ONE_U)
            begin
                rm = ONE_U;
            end
            rs = $signed(FQ_W'(rm));
            c3_cu_next[i] = c2_d_reg[i][CU_W-1] ? -rs : rs;
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] s;
        for (int r = 0; r < 3; r++)
        begin
            s = SUM_W'(t1_p_reg[r][0]) + SUM_W'(t1_p_reg[r][1]) + SUM_W'(t1_p_reg[r][2]);
            t2_rnd_next[r] = (s + HALF_S) >>> F;
        end
    end

    always_comb
    begin
        logic signed [T_W-1:0] t;
        for (int r = 0; r < 3; r++)
        begin
            t = -T_W'(t2_rnd_reg[r]);
            if (t > T_MAX)
            begin
                t = T_MAX;
            end
            else if (t < T_MIN)
            begin
                t = T_MIN;
            end
            t3_tr_next[r] = t2_ok_reg ? TW'(t) : '0;
            for (int c = 0; c < 3; c++)
            begin
                t3_ent_next[r][c] = t2_ok_reg ? EW'(t2_ent_reg[r][c]) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            c3_valid_reg <= 1'b0;
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
        end
        else
        begin
            c1_valid_reg <= in_ctl.valid;
            c2_valid_reg <= c1_valid_reg;
            c3_valid_reg <= c2_valid_reg;
            t1_valid_reg <= c3_valid_reg;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_ok_reg   <= in_ctl.ok;
        c1_p_reg[0] <= fwd[1] * right[2];
        c1_p_reg[1] <= fwd[2] * right[1];
        c1_p_reg[2] <= fwd[2] * right[0];
        c1_p_reg[3] <= fwd[0] * right[2];
        c1_p_reg[4] <= fwd[0] * right[1];
        c1_p_reg[5] <= fwd[1] * right[0];
        c1_r_reg    <= right;
        c1_f_reg    <= fwd;
        c1_e_reg    <= eye;

        c2_ok_reg   <= c1_ok_reg;
        c2_d_reg[0] <= CU_W'(c1_p_reg[0]) - CU_W'(c1_p_reg[1]);
        c2_d_reg[1] <= CU_W'(c1_p_reg[2]) - CU_W'(c1_p_reg[3]);
        c2_d_reg[2] <= CU_W'(c1_p_reg[4]) - CU_W'(c1_p_reg[5]);
        c2_r_reg    <= c1_r_reg;
        c2_f_reg    <= c1_f_reg;
        c2_e_reg    <= c1_e_reg;

        c3_ok_reg     <= c2_ok_reg;
        c3_ent_reg[0] <= c2_r_reg;
        c3_ent_reg[1] <= c3_cu_next;
        c3_ent_reg[2] <= c2_f_reg;
        c3_e_reg      <= c2_e_reg;

        t1_ok_reg <= c3_ok_reg;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                t1_p_reg[r][c] <= c3_ent_reg[r][c] * c3_e_reg[c];
            end
        end
        t1_ent_reg <= c3_ent_reg;

        t2_ok_reg  <= t1_ok_reg;
        t2_rnd_reg <= t2_rnd_next;
        t2_ent_reg <= t1_ent_reg;

        t3_degen_reg <= !t2_ok_reg;
        t3_ent_reg   <= t3_ent_next;
        t3_tr_reg    <= t3_tr_next;
    end

    assign out_valid = t3_valid_reg;
    assign out_degen = t3_degen_reg;
    assign out_ent   = t3_ent_reg;
    assign out_trans = t3_tr_reg;

endmodule

// ===== tb/sv/look_at_view_matrix_unit_tb.sv =====
// Testbench for look_at_view_matrix_unit: drives camera requests with random gaps and
// checks every emitted row against a built-in fixed-point predictor. Depends on lavm_pkg.
`timescale 1ns / 1ps

module look_at_view_matrix_unit_tb;

    typedef struct {
        logic [1:0]                   idx;
        logic [lavm_pkg::ENTRY_W-1:0] ex, ey, ez;
        logic [lavm_pkg::TRANS_W-1:0] tr;
        logic                         degen;
        logic                         last;
    } view_row_t;

    class view_row_board;
        view_row_t pending[$];
        int        errors = 0;

        function automatic longint unsigned magn(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        function automatic longint signed_of(longint unsigned m, bit neg);
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function automatic longint unsigned isqrt(longint unsigned x);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0)
            begin
                if (x >= res + b)
                begin
                    x -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        // scale so the largest magnitude lands in [2^29, 2^30)
        function automatic bit prescale(input longint v[3], output longint o[3]);
            longint unsigned m, u;
            int nb;
            m = 0;
            for (int i = 0; i < 3; i++) if (magn(v[i]) > m) m = magn(v[i]);
            for (int i = 0; i < 3; i++) o[i] = 0;
            if (m == 0) return 0;
            nb = 0;
            while (m != 0)
            begin
                nb++;
                m >>= 1;
            end
            for (int i = 0; i < 3; i++)
            begin
                u = magn(v[i]);
                if (nb > lavm_pkg::NORM_BITS) u >>= (nb - lavm_pkg::NORM_BITS);
                else u <<= (lavm_pkg::NORM_BITS - nb);
                o[i] = signed_of(u, v[i] < 0);
            end
            return 1;
        endfunction

        function automatic bit unit_vec(input longint v[3], output longint n[3]);
            longint p[3];
            longint unsigned sum, len, q;
            for (int i = 0; i < 3; i++) n[i] = 0;
            if (!prescale(v, p)) return 0;
            sum = 0;
            for (int i = 0; i < 3; i++) sum += magn(p[i]) * magn(p[i]);
            len = isqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                q = ((magn(p[i]) << lavm_pkg::FRAC_BITS) + len / 2) / len;
                n[i] = signed_of(q, p[i] < 0);
            end
            return 1;
        endfunction

        function automatic longint floor_sh(longint v);
            if (v >= 0) return v >>> lavm_pkg::FRAC_BITS;
            return -longint'((magn(v) + ((64'd1 << lavm_pkg::FRAC_BITS) - 1))
                             >> lavm_pkg::FRAC_BITS);
        endfunction

        function automatic longint trans_of(longint r[3], longint eye[3]);
            longint one, a, b, eh, el, bq, br, t;
            one = longint'(1) << lavm_pkg::FRAC_BITS;
            a = 0;
            b = 0;
            for (int i = 0; i < 3; i++)
            begin
                eh = floor_sh(eye[i]);
                el = eye[i] - eh * one;
                a += r[i] * eh;
                b += r[i] * el;
            end
            bq = floor_sh(b);
            br = b - bq * one;
            t = -(a + bq + ((br >= one / 2) ? 1 : 0));
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            return t;
        endfunction

        function automatic void queue_row(view_row_t row);
            pending.insert(pending.size(), row);
        endfunction

        // note an accepted camera request: queue its three expected rows
        function automatic void note_request(int cam[9]);
            longint eye[3], d[3], up[3], f[3], ups[3], rc[3], r[3], cu[3], one;
            longint unsigned rr;
            bit ok;
            view_row_t row;
            one = longint'(1) << lavm_pkg::FRAC_BITS;
            for (int i = 0; i < 3; i++)
            begin
                eye[i] = longint'(cam[i]);
                d[i] = longint'(cam[i]) - longint'(cam[3 + i]);
                up[i] = longint'(cam[6 + i]);
                r[i] = 0;
                cu[i] = 0;
            end
            ok = unit_vec(d, f);
            if (ok)
            begin
                void'(prescale(up, ups));
                rc[0] = ups[1] * f[2] - ups[2] * f[1];
                rc[1] = ups[2] * f[0] - ups[0] * f[2];
                rc[2] = ups[0] * f[1] - ups[1] * f[0];
                ok = unit_vec(rc, r);
            end
            if (ok)
            begin
                cu[0] = f[1] * r[2] - f[2] * r[1];
                cu[1] = f[2] * r[0] - f[0] * r[2];
                cu[2] = f[0] * r[1] - f[1] * r[0];
                for (int i = 0; i < 3; i++)
                begin
                    rr = (magn(cu[i]) + (64'd1 << (lavm_pkg::FRAC_BITS - 1)))
                         >> lavm_pkg::FRAC_BITS;
                    cu[i] = signed_of(rr, cu[i] < 0);
                    if (cu[i] > one) cu[i] = one;
                    if (cu[i] < -one) cu[i] = -one;
                end
            end
            for (int k = 0; k < lavm_pkg::ROWS_PER_ITEM; k++)
            begin
                longint v[3];
                for (int i = 0; i < 3; i++)
                    v[i] = !ok ? 0 :
                           (k == lavm_pkg::ROW_RIGHT) ? r[i] :
                           (k == lavm_pkg::ROW_CAMUP) ? cu[i] : f[i];
                row.idx   = k[1:0];
                row.ex    = v[0][lavm_pkg::ENTRY_W-1:0];
                row.ey    = v[1][lavm_pkg::ENTRY_W-1:0];
                row.ez    = v[2][lavm_pkg::ENTRY_W-1:0];
                row.tr    = ok ? lavm_pkg::TRANS_W'(trans_of(v, eye)) : '0;
                row.degen = !ok;
                row.last  = (k == lavm_pkg::ROW_FWD);
                queue_row(row);
            end
        endfunction

        task automatic report(string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task automatic check_row(view_row_t got);
            view_row_t w;
            if (pending.size() == 0)
            begin
                report("row with no request outstanding");
                return;
            end
            w = pending.pop_front();
            if (got.idx !== w.idx)
                report($sformatf("row_index %0d, want %0d", got.idx, w.idx));
            if (got.ex !== w.ex) report($sformatf("entry_x %h, want %h", got.ex, w.ex));
            if (got.ey !== w.ey) report($sformatf("entry_y %h, want %h", got.ey, w.ey));
            if (got.ez !== w.ez) report($sformatf("entry_z %h, want %h", got.ez, w.ez));
            if (got.tr !== w.tr)
                report($sformatf("translation %h, want %h", got.tr, w.tr));
            if (got.degen !== w.degen)
                report($sformatf("degenerate %b, want %b", got.degen, w.degen));
            if (got.last !== w.last)
                report($sformatf("last_row %b, want %b", got.last, w.last));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic signed [lavm_pkg::COORD_W-1:0] eye_x = 0, eye_y = 0, eye_z = 0;
    logic signed [lavm_pkg::COORD_W-1:0] target_x = 0, target_y = 0, target_z = 0;
    logic signed [lavm_pkg::COORD_W-1:0] up_x = 0, up_y = 0, up_z = 0;
    logic                                busy, done, degenerate, last_row;
    logic [1:0]                          row_index;
    logic signed [lavm_pkg::ENTRY_W-1:0] entry_x, entry_y, entry_z;
    logic signed [lavm_pkg::TRANS_W-1:0] translation;

    view_row_board board = new();

    look_at_view_matrix_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z),
        .done(done), .row_index(row_index),
        .entry_x(entry_x), .entry_y(entry_y), .entry_z(entry_z),
        .translation(translation), .degenerate(degenerate), .last_row(last_row)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        view_row_t got;
        if (rst_n && done)
        begin
            got.idx   = row_index;
            got.ex    = entry_x;
            got.ey    = entry_y;
            got.ez    = entry_z;
            got.tr    = translation;
            got.degen = degenerate;
            got.last  = last_row;
            board.check_row(got);
        end
    end

    // request is set up at a falling edge and held until a rising edge with busy low;
    // start stays high into the next request when there is no gap
    task automatic send_camera(int cam[9], int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        eye_x <= cam[0]; eye_y <= cam[1]; eye_z <= cam[2];
        target_x <= cam[3]; target_y <= cam[4]; target_z <= cam[5];
        up_x <= cam[6]; up_y <= cam[7]; up_z <= cam[8];
        start <= 1'b1;
        #1;
        while (busy) @(negedge clk);
        @(posedge clk);
        board.note_request(cam);
    endtask

    task automatic go_idle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    function automatic int small_coord();
        return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endfunction

    task automatic random_camera(output int cam[9]);
        int mode, k;
        mode = $urandom_range(0, 99);
        for (int i = 0; i < 9; i++)
            cam[i] = (mode < 45) ? int'($urandom) : small_coord();
        if (mode >= 88 && mode < 93)
        begin
            for (int i = 0; i < 3; i++) cam[3 + i] = cam[i];
        end
        else if (mode >= 93 && mode < 97)
        begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < 3; i++) cam[6 + i] = (cam[i] - cam[3 + i]) * k;
        end
        else if (mode >= 97)
        begin
            for (int i = 0; i < 3; i++) cam[6 + i] = 0;
        end
    endtask

    initial
    begin
        int directed[15][9];
        int cam[9];
        int gap;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed = '{
            '{0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0},
            '{1 << 16, 2 << 16, 3 << 16, 1 << 16, 2 << 16, 3 << 16, 0, 1 << 16, 0},
            '{0, 0, 5 << 16, 0, 0, 0, 0, 0, 0},
            '{0, 5 << 16, 0, 0, 0, 0, 0, 1 << 16, 0},
            '{0, 5 << 16, 0, 0, 0, 0, 0, -(3 << 16), 0},
            '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h80000000, 32'h80000000, 0, 1 << 16, 0},
            '{32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h7fffffff, 32'h80000000, 32'h7fffffff},
            '{32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000, 0},
            '{1, 0, 0, 0, 0, 0, 0, 0, 1},
            '{-1, -1, -1, 0, 0, 0, 1, 0, 0},
            '{32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0,
              32'h80000000, 32'h80000000, 32'h7fffffff},
            '{3 << 16, 4 << 16, 5 << 16, -(1 << 16), 1 << 16, 0,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
            '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7ffffffe, 32'h7ffffffe, 32'h7ffffffe, -1, 1, 0},
            '{0, 0, 0, 0, 0, 1 << 16, 1, 1, 1},
            '{12345, -54321, 999999, -7, 8, 9, -100000, 200000, 300000}
        };
        foreach (directed[n])
        begin
            cam = directed[n];
            send_camera(cam, (n % 3 == 0) ? 0 : $urandom_range(0, 13));
        end

        for (int n = 0; n < 370; n++)
        begin
            random_camera(cam);
            // bursts with no gap alternate with randomly idled stretches
            gap = ((n / 40) % 2 == 0) ? 0 : $urandom_range(0, 13);
            if (n == 200)
            begin
                go_idle();
                while (board.pending.size() != 0) @(negedge clk);
            end
            send_camera(cam, gap);
        end

        go_idle();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (140) @(negedge clk);
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
